### rtl/rc4_pkg.sv
// Shared types, constants and codes of the RC4 stream cipher.
`default_nettype none

package rc4_pkg;

  // Byte and permutation geometry.
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PERM_DEPTH = 256;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned KEY_LEN_W  = 5;

  // Default key capacity and reset key length.
  localparam int unsigned           KEY_BYTES_DEF = 16;
  localparam logic [KEY_LEN_W-1:0]  KEY_LEN_RESET = 5'd16;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_KEY_LEN  = 2'd2
  } rc4_cfg_idx_e;

  // Engine sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_RD,
    ST_KS_J,
    ST_KS_WK,
    ST_KS_WJ,
    ST_RD_I,
    ST_GEN_J,
    ST_GEN_T,
    ST_GEN_OUT
  } rc4_state_e;

  // One cycle of access to the permutation memory.
  typedef struct packed {
    logic              we;
    logic [BYTE_W-1:0] waddr;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] raddr;
  } rc4_mem_req_t;

endpackage

`default_nettype wire

### rtl/rc4_in_if.sv
// Input channel: one data byte and its start-of-message flag per beat.
`default_nettype none

interface rc4_in_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              start_message;

  modport source (output valid, output in_byte, output start_message, input ready);
  modport sink   (input valid, input in_byte, input start_message, output ready);
endinterface

`default_nettype wire

### rtl/rc4_out_if.sv
// Output channel: one combined byte per beat.
`default_nettype none

interface rc4_out_if;
  import rc4_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

`default_nettype wire

### rtl/rc4_perm_ram.sv
// Permutation memory: one write port and one read port with registered read data.
`default_nettype none

module rc4_perm_ram (
  input  wire logic                       clk_i,
  input  wire rc4_pkg::rc4_mem_req_t      req_i,
  output logic [rc4_pkg::BYTE_W-1:0]      rdata_o
);
  import rc4_pkg::*;

  logic [BYTE_W-1:0] mem_q [PERM_DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read port returns the contents before a same-cycle write.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire

### rtl/rc4_key_regs.sv
// Key configuration registers and effective key length.
`default_nettype none

module rc4_key_regs #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    cfg_we_i,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output logic [KEY_BYTES-1:0][rc4_pkg::BYTE_W-1:0]    key_o,
  output logic [rc4_pkg::KEY_LEN_W-1:0]                key_len_o
);
  import rc4_pkg::*;

  localparam int unsigned BYTES_PER_WORD = CFG_DATA_W / BYTE_W;

  logic [KEY_LEN_W-1:0] key_len_q;

  // Key bytes: each one belongs to a fixed byte lane of one of the two key words.
  for (genvar b = 0; b < KEY_BYTES; b++) begin : g_key
    localparam rc4_cfg_idx_e WORD = (b < BYTES_PER_WORD) ? CFG_KEY_LOW : CFG_KEY_HIGH;
    localparam int unsigned  OFS  = (b % BYTES_PER_WORD) * BYTE_W;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        key_o[b] <= '0;
      end else if (cfg_we_i && (rc4_cfg_idx_e'(cfg_idx_i) == WORD)) begin
        key_o[b] <= cfg_data_i[OFS +: BYTE_W];
      end
    end
  end

  // Key length register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_we_i && (rc4_cfg_idx_e'(cfg_idx_i) == CFG_KEY_LEN)) begin
      key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
    end
  end

  // A length of zero acts as one; lengths above the key capacity saturate.
  always_comb begin
    if (key_len_q == '0) begin
      key_len_o = KEY_LEN_W'(1);
    end else if (key_len_q > KEY_LEN_W'(KEY_BYTES)) begin
      key_len_o = KEY_LEN_W'(KEY_BYTES);
    end else begin
      key_len_o = key_len_q;
    end
  end

endmodule

`default_nettype wire

### rtl/rc4_engine.sv
// Sequencer and datapath for the key schedule and keystream generation.
`default_nettype none

module rc4_engine #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  rc4_in_if.sink                                       in_i,
  rc4_out_if.source                                    out_o,
  input  wire logic [KEY_BYTES-1:0][rc4_pkg::BYTE_W-1:0] key_i,
  input  wire logic [rc4_pkg::KEY_LEN_W-1:0]           key_len_i,
  output rc4_pkg::rc4_mem_req_t                        mem_req_o,
  input  wire logic [rc4_pkg::BYTE_W-1:0]              mem_rdata_i
);
  import rc4_pkg::*;

  localparam int unsigned KIDX_W = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam logic [BYTE_W-1:0] LAST_ENTRY = BYTE_W'(PERM_DEPTH - 1);

  rc4_state_e state_q, state_d;

  logic              keyed_q, keyed_d;
  logic [BYTE_W-1:0] i_q, i_d;
  logic [BYTE_W-1:0] j_q, j_d;
  logic [BYTE_W-1:0] k_q, k_d;
  logic [KIDX_W-1:0] kidx_q, kidx_d;
  logic [BYTE_W-1:0] si_q, si_d;
  logic [BYTE_W-1:0] sj_q, sj_d;
  logic [BYTE_W-1:0] t_q, t_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;

  logic              in_acc;
  logic              need_key;
  logic              out_free;
  logic [BYTE_W-1:0] j_new;
  logic [BYTE_W-1:0] t_new;
  logic [BYTE_W-1:0] ks_byte;
  logic [KEY_LEN_W-1:0] kidx_inc;

  // Handshake helpers.
  assign in_acc   = in_i.valid && in_i.ready;
  assign need_key = in_i.start_message || !keyed_q;
  assign out_free = !out_valid_q || out_o.ready;
  assign kidx_inc = KEY_LEN_W'(kidx_q) + KEY_LEN_W'(1);

  // Keystream byte: the swap is still being written to memory when entry t is read, so entries i and j
  // are taken from the saved values, with j winning when both indices match.
  always_comb begin
    if (t_q == j_q) begin
      ks_byte = si_q;
    end else if (t_q == i_q) begin
      ks_byte = sj_q;
    end else begin
      ks_byte = mem_rdata_i;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = need_key ? ST_INIT : ST_GEN_J;
        end
      end
      ST_INIT: begin
        if (k_q == LAST_ENTRY) begin
          state_d = ST_KS_RD;
        end
      end
      ST_KS_RD:  state_d = ST_KS_J;
      ST_KS_J:   state_d = ST_KS_WK;
      ST_KS_WK:  state_d = ST_KS_WJ;
      ST_KS_WJ:  state_d = (k_q == LAST_ENTRY) ? ST_RD_I : ST_KS_RD;
      ST_RD_I:   state_d = ST_GEN_J;
      ST_GEN_J:  state_d = ST_GEN_T;
      ST_GEN_T:  state_d = ST_GEN_OUT;
      ST_GEN_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    keyed_d     = keyed_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    kidx_d      = kidx_q;
    si_d        = si_q;
    sj_d        = sj_q;
    t_d         = t_q;
    data_d      = data_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    j_new       = j_q + mem_rdata_i;
    t_new       = si_q + mem_rdata_i;

    mem_req_o.we    = 1'b0;
    mem_req_o.waddr = k_q;
    mem_req_o.wdata = k_q;
    mem_req_o.raddr = i_q + BYTE_W'(1);

    in_i.ready = (state_q == ST_IDLE);

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        // Entry i+1 is read speculatively; it is used when no key schedule runs.
        if (in_acc) begin
          data_d = in_i.in_byte;
          if (need_key) begin
            k_d = '0;
          end else begin
            i_d = i_q + BYTE_W'(1);
          end
        end
      end
      ST_INIT: begin
        mem_req_o.we = 1'b1;
        k_d          = k_q + BYTE_W'(1);
        j_d          = '0;
        kidx_d       = '0;
      end
      ST_KS_RD: begin
        mem_req_o.raddr = k_q;
      end
      ST_KS_J: begin
        j_new           = j_q + mem_rdata_i + key_i[kidx_q];
        j_d             = j_new;
        si_d            = mem_rdata_i;
        mem_req_o.raddr = j_new;
      end
      ST_KS_WK: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = k_q;
        mem_req_o.wdata = mem_rdata_i;
      end
      ST_KS_WJ: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
        k_d             = k_q + BYTE_W'(1);
        kidx_d          = (kidx_inc == key_len_i) ? '0 : kidx_q + KIDX_W'(1);
        if (k_q == LAST_ENTRY) begin
          i_d     = '0;
          j_d     = '0;
          keyed_d = 1'b1;
        end
      end
      ST_RD_I: begin
        i_d = i_q + BYTE_W'(1);
      end
      ST_GEN_J: begin
        si_d            = mem_rdata_i;
        j_d             = j_new;
        mem_req_o.raddr = j_new;
      end
      ST_GEN_T: begin
        sj_d            = mem_rdata_i;
        t_d             = t_new;
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = i_q;
        mem_req_o.wdata = mem_rdata_i;
        mem_req_o.raddr = t_new;
      end
      ST_GEN_OUT: begin
        mem_req_o.we    = 1'b1;
        mem_req_o.waddr = j_q;
        mem_req_o.wdata = si_q;
        mem_req_o.raddr = t_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_byte_d  = data_q ^ ks_byte;
        end
      end
      default: begin
        mem_req_o.we = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keyed_q     <= 1'b0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      keyed_q     <= keyed_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    kidx_q     <= kidx_d;
    si_q       <= si_d;
    sj_q       <= sj_d;
    t_q        <= t_d;
    data_q     <= data_d;
    out_byte_q <= out_byte_d;
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;

  // The memory is left alone while waiting for a beat.
  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !mem_req_o.we)
    else $error("permutation written while idle");

  // A new result is only produced at the end of a generator pass.
  a_out_from_gen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_GEN_OUT))
    else $error("result produced outside the generator pass");

  // Generation never runs on an unkeyed permutation.
  a_gen_keyed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GEN_J) |-> keyed_q)
    else $error("keystream generated before the key schedule");

  // The cyclic key index stays below the effective key length.
  a_kidx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_KS_J) |-> (KEY_LEN_W'(kidx_q) < key_len_i))
    else $error("key byte index out of range");

endmodule

`default_nettype wire

### rtl/rc4_stream_cipher_top.sv
// Top level of the RC4 stream cipher: key registers, engine and permutation memory.
`default_nettype none

// Each input beat yields exactly one output beat: the input byte XORed with the next
// RC4 keystream byte. Its pace is set by the three dependent reads on the one read
// port of the permutation memory plus the write-back of the swap; one finished byte
// may wait in the output register while the next one is accepted and processed. A
// beat with start_message set, and the first beat after reset, first runs the key
// schedule, which loads the identity permutation and then mixes in the key one entry
// at a time. Key registers must be written over the cfg port only while the block is
// idle; the block itself does not enforce this. New values take effect at the next
// key schedule. key_length of zero acts as one, and values above KEY_BYTES saturate.
module rc4_stream_cipher_top #(
  parameter int unsigned KEY_BYTES = rc4_pkg::KEY_BYTES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  rc4_in_if.sink                               in_i,
  rc4_out_if.source                            out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [rc4_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [rc4_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import rc4_pkg::*;

  logic [KEY_BYTES-1:0][BYTE_W-1:0] key;
  logic [KEY_LEN_W-1:0]             key_len;
  rc4_mem_req_t                     mem_req;
  logic [BYTE_W-1:0]                mem_rdata;

  // Configuration registers.
  rc4_key_regs #(
    .KEY_BYTES (KEY_BYTES)
  ) u_key_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .key_o      (key),
    .key_len_o  (key_len)
  );

  // Sequencer and datapath.
  rc4_engine #(
    .KEY_BYTES (KEY_BYTES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .key_i       (key),
    .key_len_i   (key_len),
    .mem_req_o   (mem_req),
    .mem_rdata_i (mem_rdata)
  );

  // Permutation storage.
  rc4_perm_ram u_perm_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

endmodule

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for the RC4 stream cipher top level.
`timescale 1ns / 1ps

module testbench;
  import rc4_pkg::*;

  localparam int unsigned KEY_BYTES    = KEY_BYTES_DEF;
  localparam int unsigned STALL_LIMIT  = 8000;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_ITEMS = 925;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned TAIL_CYCLES  = 16;

  // Index past the end of the register list; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef logic [BYTE_W-1:0] byte_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rc4_in_if  in_ch ();
  rc4_out_if out_ch ();

  rc4_stream_cipher_top #(
    .KEY_BYTES (KEY_BYTES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Mirror of the cipher state and key registers.
  byte_t                 perm_mirror [PERM_DEPTH];
  byte_t                 gen_i;
  byte_t                 gen_j;
  logic                  perm_keyed;
  logic [CFG_DATA_W-1:0] key_low;
  logic [CFG_DATA_W-1:0] key_high;
  logic [KEY_LEN_W-1:0]  key_len;

  // Bytes predicted for the output channel, oldest first.
  byte_t expected_bytes [$];

  logic        tx_idle_on;
  logic        rx_idle_on;
  int unsigned hold_request;
  int unsigned quiet_cycles    = 0;
  int unsigned err_count       = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned key_schedules   = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Key byte n of the 16-byte key held in the two key words.
  function automatic byte_t key_byte_at(int unsigned n);
    logic [CFG_DATA_W-1:0] word;
    word = (n < 8) ? key_low : key_high;
    return word[(n % 8) * 8 +: 8];
  endfunction

  // Key schedule: identity permutation, then 256 mixing swaps.
  function automatic void run_key_schedule();
    int unsigned len;
    byte_t       j;
    byte_t       t;
    len = (key_len == 0) ? 1 : ((key_len > KEY_BYTES) ? KEY_BYTES : key_len);
    for (int k = 0; k < PERM_DEPTH; k++) perm_mirror[k] = byte_t'(k);
    j = '0;
    for (int k = 0; k < PERM_DEPTH; k++) begin
      j              = j + perm_mirror[k] + key_byte_at(k % len);
      t              = perm_mirror[k];
      perm_mirror[k] = perm_mirror[j];
      perm_mirror[j] = t;
    end
    gen_i         = '0;
    gen_j         = '0;
    perm_keyed    = 1'b1;
    key_schedules = key_schedules + 1;
  endfunction

  // Advance the generator by one step and combine its byte with the data.
  function automatic byte_t cipher_byte(byte_t data, logic start);
    byte_t t;
    if (start || !perm_keyed) run_key_schedule();
    gen_i              = gen_i + 8'd1;
    gen_j              = gen_j + perm_mirror[gen_i];
    t                  = perm_mirror[gen_i];
    perm_mirror[gen_i] = perm_mirror[gen_j];
    perm_mirror[gen_j] = t;
    t                  = perm_mirror[gen_i] + perm_mirror[gen_j];
    return data ^ perm_mirror[t];
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Offer one input beat and wait until it is taken.
  task automatic send_byte(input byte_t data, input logic start);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= data;
    in_ch.start_message <= start;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Stop offering input and wait until every predicted byte has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (expected_bytes.size() != 0);
  endtask

  // One register write; the mirror follows once the write has taken place.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_KEY_LOW:  key_low  = data;
      CFG_KEY_HIGH: key_high = data;
      CFG_KEY_LEN:  key_len  = data[KEY_LEN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_key(input logic [CFG_DATA_W-1:0] low_word,
                         input logic [CFG_DATA_W-1:0] high_word,
                         input logic [CFG_DATA_W-1:0] len_word);
    write_reg(CFG_KEY_LOW, low_word);
    write_reg(CFG_KEY_HIGH, high_word);
    write_reg(CFG_KEY_LEN, len_word);
  endtask

  function automatic logic [CFG_DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Check every output beat and predict every input beat.
  always @(posedge clk_i) begin : result_check
    byte_t expected;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (expected_bytes.size() == 0) begin
          flag_error($sformatf("unexpected out_byte %02h", out_ch.out_byte));
        end else begin
          expected = expected_bytes.pop_front();
          if (out_ch.out_byte !== expected)
            flag_error($sformatf("out_byte expected %02h actual %02h",
                                 expected, out_ch.out_byte));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        items_accepted++;
        expected_bytes.push_back(cipher_byte(in_ch.in_byte, in_ch.start_message));
      end
    end
  end

  // Watchdog on cycles without any beat on either channel.
  always @(posedge clk_i) begin : stall_watch
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", quiet_cycles);
      $display("rc4_stream_cipher_top test failed");
      $finish;
    end
  end

  // Output side: random stalls per beat, plus a long hold-off on request.
  initial begin : result_sink
    int unsigned pause;
    out_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_request > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_request) @(posedge clk_i);
        hold_request = 0;
      end
      pause = rx_idle_on ? $urandom_range(0, 9) : 0;
      if (pause > 0) begin
        out_ch.ready <= 1'b0;
        repeat (pause) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Reset key values; the first byte must run the key schedule on its own.
  task automatic test_first_byte_after_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    drain();
  endtask

  // Shortest, full, zero and oversized key lengths.
  task automatic test_key_lengths();
    set_key('1, '1, 1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    drain();
    set_key(random_word(), random_word(), KEY_BYTES);
    send_byte(8'h5A, 1'b1);
    send_byte(8'h81, 1'b0);
    drain();
    set_key(random_word(), random_word(), 0);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h01, 1'b0);
    drain();
    // All ones: only the low bits count, and 31 saturates to the key capacity.
    write_reg(CFG_KEY_LEN, '1);
    send_byte(8'h80, 1'b1);
    send_byte(8'hC3, 1'b0);
    drain();
  endtask

  // A new key must not disturb the running keystream until the next start.
  task automatic test_key_change_mid_message();
    set_key(random_word(), random_word(), 7);
    send_byte(byte_t'($urandom), 1'b1);
    send_byte(byte_t'($urandom), 1'b0);
    drain();
    set_key(random_word(), random_word(), 12);
    send_byte(byte_t'($urandom), 1'b0);
    send_byte(byte_t'($urandom), 1'b1);
    drain();
  endtask

  // A write past the register list leaves both stream and key alone.
  task automatic test_unused_register();
    write_reg(CFG_IDX_UNUSED, random_word());
    send_byte(byte_t'($urandom), 1'b0);
    send_byte(byte_t'($urandom), 1'b1);
    drain();
  endtask

  // Long output hold-off while input keeps coming, so the input stalls.
  task automatic test_back_pressure();
    tx_idle_on   = 1'b0;
    rx_idle_on   = 1'b0;
    hold_request = HOLD_CYCLES;
    for (int n = 0; n < 8; n++) send_byte(byte_t'($urandom), 1'b0);
    drain();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  // Messages of random length and content, with occasional key changes.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned msg_len;
    logic        start;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0)
        set_key(random_word(), random_word(), $urandom_range(0, 31));
      msg_len = $urandom_range(1, 60);
      for (int n = 0; n < msg_len; n++) begin
        // Most messages open with a start; some continue the old keystream.
        start = ((n == 0) && ($urandom_range(0, 9) != 0)) || ($urandom_range(0, 99) == 0);
        send_byte(byte_t'($urandom), start);
      end
      sent += msg_len;
      drain();
    end
  endtask

  initial begin : main_seq
    in_ch.valid         <= 1'b0;
    in_ch.in_byte       <= '0;
    in_ch.start_message <= 1'b0;
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= CFG_KEY_LOW;
    cfg_data_i          <= '0;
    rst_ni              <= 1'b0;
    tx_idle_on   = 1'b1;
    rx_idle_on   = 1'b1;
    hold_request = 0;
    key_low      = '0;
    key_high     = '0;
    key_len      = KEY_LEN_RESET;
    perm_keyed   = 1'b0;
    gen_i        = '0;
    gen_j        = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_byte_after_reset();
    test_key_lengths();
    test_key_change_mid_message();
    test_unused_register();
    test_back_pressure();
    test_random_stream();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_bytes.size() != 0)
      flag_error($sformatf("%0d predicted bytes never came out", expected_bytes.size()));

    $display("Sent %0d bytes through %0d key schedules, with key lengths 0 to 31,",
             items_accepted, key_schedules);
    $display("random stalls on both sides and one long output hold-off; %0d errors.",
             err_count);
    if (err_count == 0) begin
      $display("rc4_stream_cipher_top test passed");
    end else begin
      $display("rc4_stream_cipher_top test failed");
    end
    $finish;
  end

endmodule
